### rtl/dq_pkg.sv
package dq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    localparam int VALUE_W = 64;
    localparam int MODE_W = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W = 5;
    localparam int OUT_DATA_W = 136;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK = 3'd1;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_BACK = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REVERSE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic rd;
        logic load_out;
    } t_dp_cmd;

endpackage

### rtl/dq_ctrl.sv
module dq_ctrl
    import dq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WRITE = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_LOAD = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       load_out;

    assign o_in_ready = (r_state == S_IDLE);
    assign load_out = (r_state == S_LOAD) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_WRITE;
            end
            S_WRITE: n_state = S_READ;
            S_READ: n_state = S_LOAD;
            S_LOAD: begin
                if (load_out) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_comb begin
        o_cmd.load_in = (r_state == S_IDLE) && i_in_valid;
        o_cmd.exec = (r_state == S_WRITE);
        o_cmd.rd = (r_state == S_READ);
        o_cmd.load_out = load_out;
    end

    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

### rtl/dq_dp.sv
module dq_dp
    import dq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    input  logic [MODE_W-1:0]     i_mode,
    input  logic [VALUE_W-1:0]    i_value,
    output logic [VALUE_W-1:0]    o_front_value,
    output logic [VALUE_W-1:0]    o_back_value,
    output logic                  o_empty_res,
    output logic                  o_full_res,
    output logic [COUNT_W-1:0]    o_entry_count,
    output logic [STATUS_W-1:0]   o_status
);

    logic [VALUE_W-1:0] mem [DEPTH];

    logic [MODE_W-1:0]   r_mode;
    logic [VALUE_W-1:0]  r_value;
    logic [IDX_W-1:0]    r_head, n_head;
    logic [CNT_W-1:0]    r_occ, n_occ;
    logic                r_rev, n_rev;
    logic [STATUS_W-1:0] r_status, n_status;
    logic                we;
    logic [IDX_W-1:0]    waddr;
    logic [VALUE_W-1:0]  r_rd_f, r_rd_b;
    logic [VALUE_W-1:0]  r_front, r_back;
    logic                r_empty, r_full;
    logic [COUNT_W-1:0]  r_count;
    logic                at_front;
    logic                is_full, is_empty;
    logic [IDX_W-1:0]    push_back_addr, next_head, tail_addr;
    logic [CNT_W-1:0]    tail_off;
    logic [CNT_W+COUNT_W-1:0] count_ext;

    function automatic logic [IDX_W-1:0] ring_at(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] p;
        p = SUM_W'(head) + SUM_W'(off);
        if (p >= SUM_W'(DEPTH)) p = p - SUM_W'(DEPTH);
        return p[IDX_W-1:0];
    endfunction

    assign is_full = (r_occ >= CNT_W'(DEPTH));
    assign is_empty = (r_occ == '0);
    assign push_back_addr = ring_at(r_head, r_occ);
    assign next_head = ring_at(r_head, CNT_W'(1));
    assign tail_off = is_empty ? '0 : r_occ - CNT_W'(1);
    assign tail_addr = ring_at(r_head, tail_off);

    always_comb begin
        n_head = r_head;
        n_occ = r_occ;
        n_rev = r_rev;
        n_status = ST_OK;
        we = 1'b0;
        waddr = push_back_addr;
        at_front = 1'b0;
        case (r_mode)
            MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                at_front = (r_mode == MODE_PUSH_FRONT) ^ r_rev;
                if (is_full) begin
                    n_status = ST_OVERFLOW;
                end else if (at_front) begin
                    n_head = (r_head == '0) ? IDX_W'(DEPTH - 1) : r_head - IDX_W'(1);
                    waddr = n_head;
                    we = 1'b1;
                    n_occ = r_occ + CNT_W'(1);
                end else begin
                    we = 1'b1;
                    n_occ = r_occ + CNT_W'(1);
                end
            end
            MODE_POP_FRONT, MODE_POP_BACK: begin
                at_front = (r_mode == MODE_POP_FRONT) ^ r_rev;
                if (is_empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    if (at_front) n_head = next_head;
                    n_occ = r_occ - CNT_W'(1);
                end
            end
            MODE_REVERSE: n_rev = !r_rev;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && we) mem[waddr] <= r_value;
        if (i_cmd.rd) begin
            r_rd_f <= mem[r_head];
            r_rd_b <= mem[tail_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_occ <= '0;
            r_rev <= 1'b0;
        end else if (i_cmd.exec) begin
            r_head <= n_head;
            r_occ <= n_occ;
            r_rev <= n_rev;
        end
    end

    assign count_ext = {{COUNT_W{1'b0}}, r_occ};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode <= i_mode;
            r_value <= i_value;
        end
        if (i_cmd.exec) r_status <= n_status;
        if (i_cmd.load_out) begin
            r_front <= is_empty ? '0 : (r_rev ? r_rd_b : r_rd_f);
            r_back <= is_empty ? '0 : (r_rev ? r_rd_f : r_rd_b);
            r_empty <= is_empty;
            r_full <= (r_occ == CNT_W'(DEPTH));
            r_count <= count_ext[COUNT_W-1:0];
            o_status <= r_status;
        end
    end

    assign o_front_value = r_front;
    assign o_back_value = r_back;
    assign o_empty_res = r_empty;
    assign o_full_res = r_full;
    assign o_entry_count = r_count;

endmodule

### rtl/double_ended_queue.sv
// Bounded deque of 64-bit values held in a ring buffer of DEPTH entries.
// Input channel (s_axis): tuser carries the mode (push front, push back,
// pop front, pop back, reverse), tdata the value to push. Output channel
// (m_axis): one beat per input beat with the front and back values, the
// empty and full flags and the entry count in tdata, the status in tuser.
// Reverse only flips a direction flag; the ends swap without moving data.
// The input beat is registered; the block then writes the entry and updates
// the pointers, does the registered two-port read of the entry memory, and
// loads the result register; only then is a new input beat taken.
// A new input beat may be taken while the previous result still waits in
// the output register; the block then holds before loading the next result
// until the receiver takes the pending beat, and tready stays low.
// Reset empties the deque and clears the direction flag; memory contents
// are not cleared, and unwritten entries never reach the output.
module double_ended_queue
    import dq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [VALUE_W-1:0]    i_s_axis_tdata,  // value[63:0]
    input  logic [MODE_W-1:0]     i_s_axis_tuser,  // mode[2:0]
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // front_value[63:0], back_value[127:64], empty_res[128], full_res[129],
    // entry_count[134:130], zero pad[135]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic [STATUS_W-1:0]   o_m_axis_tuser   // status[1:0]
);

    t_dp_cmd             cmd;
    logic [VALUE_W-1:0]  front_value, back_value;
    logic                empty_res, full_res;
    logic [COUNT_W-1:0]  entry_count;

    dq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd)
    );

    dq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_mode        (i_s_axis_tuser),
        .i_value       (i_s_axis_tdata),
        .o_front_value (front_value),
        .o_back_value  (back_value),
        .o_empty_res   (empty_res),
        .o_full_res    (full_res),
        .o_entry_count (entry_count),
        .o_status      (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {1'b0, entry_count, full_res, empty_res, back_value, front_value};

endmodule

### rtl/dq_checker.sv
module dq_checker
    import dq_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [STATUS_W-1:0]   o_m_axis_tuser
);

    a_not_empty_and_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !(o_m_axis_tdata[128] && o_m_axis_tdata[129]))
        else $error("empty and full both set");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[128]) |-> (o_m_axis_tdata[134:130] == 5'd0))
        else $error("empty with nonzero count");

    a_empty_values: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[128]) |-> (o_m_axis_tdata[127:0] == 128'd0))
        else $error("empty with nonzero end values");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == ST_OK || o_m_axis_tuser == ST_OVERFLOW
                             || o_m_axis_tuser == ST_UNDERFLOW))
        else $error("bad status code");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("stalled output beat changed");

endmodule

bind double_ended_queue dq_checker u_dq_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import dq_pkg::*;

    localparam logic [MODE_W-1:0] MODE_NOP_A = 3'd5;
    localparam logic [MODE_W-1:0] MODE_NOP_B = 3'd6;
    localparam logic [MODE_W-1:0] MODE_NOP_C = 3'd7;
    localparam int STALL_LIMIT = 5000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [VALUE_W-1:0]  front_value;
        logic [VALUE_W-1:0]  back_value;
        logic                empty_res;
        logic                full_res;
        logic [COUNT_W-1:0]  entry_count;
        logic [STATUS_W-1:0] status;
    } t_deque_snapshot;

    class t_deque_scoreboard;
        logic [VALUE_W-1:0] ring [DEPTH];
        int head;
        int occ;
        bit flipped;
        t_deque_snapshot expected_snapshots[$];
        int mismatches;

        function new();
            head = 0;
            occ = 0;
            flipped = 1'b0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_snapshots.size();
        endfunction

        // Applies one accepted input beat and queues the snapshot it must produce.
        function void note_operation(logic [MODE_W-1:0] mode, logic [VALUE_W-1:0] value);
            t_deque_snapshot snap;
            logic [VALUE_W-1:0] phys_front;
            logic [VALUE_W-1:0] phys_back;
            bit at_front;
            snap.status = ST_OK;
            case (mode)
                MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                    if (occ >= DEPTH) begin
                        snap.status = ST_OVERFLOW;
                    end else begin
                        at_front = (mode == MODE_PUSH_FRONT) != flipped;
                        if (at_front) begin
                            head = (head + DEPTH - 1) % DEPTH;
                            ring[head] = value;
                        end else begin
                            ring[(head + occ) % DEPTH] = value;
                        end
                        occ++;
                    end
                end
                MODE_POP_FRONT, MODE_POP_BACK: begin
                    if (occ == 0) begin
                        snap.status = ST_UNDERFLOW;
                    end else begin
                        at_front = (mode == MODE_POP_FRONT) != flipped;
                        if (at_front) begin
                            head = (head + 1) % DEPTH;
                        end
                        occ--;
                    end
                end
                MODE_REVERSE: begin
                    flipped = !flipped;
                end
                default: begin
                end
            endcase
            phys_front = '0;
            phys_back = '0;
            if (occ != 0) begin
                phys_front = ring[head];
                phys_back = ring[(head + occ - 1) % DEPTH];
            end
            snap.front_value = flipped ? phys_back : phys_front;
            snap.back_value = flipped ? phys_front : phys_back;
            snap.empty_res = (occ == 0);
            snap.full_res = (occ == DEPTH);
            snap.entry_count = COUNT_W'(occ);
            expected_snapshots.push_back(snap);
        endfunction

        function void compare_field(string name, logic [VALUE_W-1:0] exp_v,
                                    logic [VALUE_W-1:0] act_v);
            if (act_v !== exp_v) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: %s mismatch, expected %h, got %h", $realtime, name,
                             exp_v, act_v);
                end
            end
        endfunction

        function void check_snapshot(logic [OUT_DATA_W-1:0] data, logic [STATUS_W-1:0] st);
            t_deque_snapshot snap;
            if (expected_snapshots.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: result beat with nothing expected, tdata %h", $realtime,
                             data);
                end
            end else begin
                snap = expected_snapshots.pop_front();
                compare_field("front_value", snap.front_value, data[63:0]);
                compare_field("back_value", snap.back_value, data[127:64]);
                compare_field("empty_res", 64'(snap.empty_res), 64'(data[128]));
                compare_field("full_res", 64'(snap.full_res), 64'(data[129]));
                compare_field("entry_count", 64'(snap.entry_count), 64'(data[134:130]));
                compare_field("status", 64'(snap.status), 64'(st));
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_axis_tvalid;
    logic                  o_s_axis_tready;
    logic [VALUE_W-1:0]    i_s_axis_tdata;   // value[63:0]
    logic [MODE_W-1:0]     i_s_axis_tuser;   // mode[2:0]
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready;
    // front_value[63:0], back_value[127:64], empty_res[128], full_res[129],
    // entry_count[134:130], zero pad[135]
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;
    logic [STATUS_W-1:0]   o_m_axis_tuser;   // status[1:0]

    t_deque_scoreboard sb = new();
    int send_idle_pct = 37;
    int recv_idle_pct = 65;
    int stall_cycles = 0;

    double_ended_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            sb.check_snapshot(o_m_axis_tdata, o_m_axis_tuser);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tuser = mode;
        i_s_axis_tdata = value;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_operation(mode, value);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) begin
            @(negedge i_clk);
        end
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(int push_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < 8) begin
            return MODE_REVERSE;
        end else if (roll < 11) begin
            case ($urandom_range(2))
                0: return MODE_NOP_A;
                1: return MODE_NOP_B;
                default: return MODE_NOP_C;
            endcase
        end else if ($urandom_range(99) < push_pct) begin
            return $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        end
        return $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
    endfunction

    // Bursts that lean toward pushes, toward pops or neither, so that full and empty are hit often.
    task automatic run_random(input int count, input int s_pct, input int r_pct);
        int burst_left;
        int push_pct;
        burst_left = 0;
        push_pct = 50;
        wait_drained();
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(4, 40);
                case ($urandom_range(2))
                    0: push_pct = 85;
                    1: push_pct = 50;
                    default: push_pct = 15;
                endcase
            end
            burst_left--;
            send_beat(pick_mode(push_pct), pick_value());
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = MODE_PUSH_FRONT;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty deque: underflow, reverse, spare modes
        send_beat(MODE_POP_FRONT, '0);
        send_beat(MODE_POP_BACK, '1);
        send_beat(MODE_REVERSE, '0);
        send_beat(MODE_NOP_A, '1);
        send_beat(MODE_NOP_B, 64'h5555_5555_5555_5555);
        send_beat(MODE_NOP_C, 64'hAAAA_AAAA_AAAA_AAAA);
        // reversed pushes, then back to normal order and fill up
        send_beat(MODE_PUSH_FRONT, '0);
        send_beat(MODE_PUSH_BACK, '1);
        send_beat(MODE_REVERSE, '0);
        send_beat(MODE_PUSH_FRONT, 64'h5555_5555_5555_5555);
        send_beat(MODE_PUSH_BACK, 64'hAAAA_AAAA_AAAA_AAAA);
        for (int i = 0; i < 12; i++) begin
            send_beat((i % 2) ? MODE_PUSH_BACK : MODE_PUSH_FRONT, {$urandom, 32'(i)});
        end
        // full deque: overflow on both ends, then pops
        send_beat(MODE_PUSH_BACK, '1);
        send_beat(MODE_PUSH_FRONT, '0);
        send_beat(MODE_POP_FRONT, '0);
        send_beat(MODE_POP_BACK, '0);

        run_random(240, 37, 65);
        run_random(240, 65, 37);
        run_random(245, 0, 0);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
